>>> hdl/tcfe_pkg.sv
// Package for the template-checked field extractor.
// Holds the message template, character codes, widths and defaults.
// No dependencies.
`timescale 1ns / 1ps

package tcfe_pkg;

    localparam int POS_W         = 7;
    localparam int FIELD_W       = 4;
    localparam int VALUE_W       = 14;
    localparam int DIGIT_CNT_W   = 3;
    localparam int BYTE_W        = 8;
    localparam int OUT_TDATA_W   = 24;

    localparam int FRAME_LENGTH_DEF     = 104;
    localparam int FIELD_COUNT_DEF      = 11;
    localparam int DIGITS_PER_FIELD_DEF = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COMMA = 8'h2c;

    localparam int TEMPLATE_LEN = 103;
    localparam logic [8*TEMPLATE_LEN-1:0] TEMPLATE_TEXT =
        {"mMin:0000,mMax:0000,hMin:0000,hMax:0000,tMin:0000,tMax:0000,",
         "iMin:0000,iMax:0000,h:0000,t:0000,nID:0000,"};

    typedef struct packed {
        logic [POS_W-1:0]       byte_position;
        logic [FIELD_W-1:0]     current_field;
        logic [VALUE_W-1:0]     digit_accumulator;
        logic                   mismatch_flag;
        logic [DIGIT_CNT_W-1:0] digits_taken;
    } parse_state_t;

    function automatic logic [7:0] template_byte(input logic [POS_W-1:0] pos);
        logic [7:0] b;
        b = 8'h00;
        if (int'(pos) < TEMPLATE_LEN)
        begin
            b = TEMPLATE_TEXT[8*(TEMPLATE_LEN-1-int'(pos)) +: 8];
        end
        return b;
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

>>> hdl/template_checked_field_extractor_top.sv
// Top level of the template-checked field extractor.
// Depends on tcfe_pkg for the template ROM, codes and state type.
// Single module: input register, parse logic, result register.
`timescale 1ns / 1ps

// Receives a message one ASCII byte per request on s_axis and checks each byte
// against the fixed template: digit positions must hold '0'..'9', all others
// must match exactly. At each template comma a result carries the field number
// and its decimal value in m_axis_tdata, the running error flag in
// m_axis_tuser and message end in m_axis_tlast. tuser on s_axis marks the first
// byte of a new message. A byte is taken every cycle unless a held result is
// stalled on m_axis; each byte passes through the input register, and a comma
// byte's result is then loaded into the result register, where it is held
// while m_axis stalls. Bytes past the end of the message are dropped
// without a result.
module template_checked_field_extractor_top
    import tcfe_pkg::*;
#(
    parameter int FRAME_LENGTH     = FRAME_LENGTH_DEF,
    parameter int FIELD_COUNT      = FIELD_COUNT_DEF,
    parameter int DIGITS_PER_FIELD = DIGITS_PER_FIELD_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] rx_byte
    input  logic                   s_axis_tuser,   // [0] start_of_message
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [3:0] field_index, [17:4] field_value
    output logic                   m_axis_tuser,   // [0] error_so_far
    output logic                   m_axis_tlast    // message_last
);

    logic                   in_valid_reg;
    logic [BYTE_W-1:0]      rx_reg;
    logic                   som_reg;
    parse_state_t           state_reg;
    parse_state_t           state_next;
    parse_state_t           base;
    logic                   out_valid_reg;
    logic [FIELD_W-1:0]     field_index_reg;
    logic [VALUE_W-1:0]     field_value_reg;
    logic                   error_reg;
    logic                   last_reg;

    logic                   out_free;
    logic                   advance;
    logic                   produce;
    logic [7:0]             tmpl;
    logic                   in_span;
    logic [VALUE_W-1:0]     acc_step;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            rx_reg  <= s_axis_tdata;
            som_reg <= s_axis_tuser;
        end
    end

    always_comb
    begin
        base = state_reg;
        if (som_reg)
        begin
            base = '0;
        end
        state_next = base;
        produce    = 1'b0;
        tmpl       = template_byte(base.byte_position);
        in_span    = {1'b0, base.byte_position} < 8'(FRAME_LENGTH - 1);
        acc_step   = {base.digit_accumulator[VALUE_W-4:0], 3'b000}
                   + {base.digit_accumulator[VALUE_W-2:0], 1'b0}
                   + (is_decimal(rx_reg) ? VALUE_W'(rx_reg[3:0]) : '0);
        if (in_span)
        begin
            if (is_decimal(tmpl))
            begin
                if (!is_decimal(rx_reg))
                begin
                    state_next.mismatch_flag = 1'b1;
                end
                if (base.digits_taken < DIGIT_CNT_W'(DIGITS_PER_FIELD))
                begin
                    state_next.digit_accumulator = acc_step;
                    state_next.digits_taken      = base.digits_taken + 1'b1;
                end
            end
            else
            begin
                if (rx_reg != tmpl)
                begin
                    state_next.mismatch_flag = 1'b1;
                end
                if (tmpl == CHAR_COMMA)
                begin
                    produce = {1'b0, base.current_field} < 5'(FIELD_COUNT);
                    if (base.current_field != '1)
                    begin
                        state_next.current_field = base.current_field + 1'b1;
                    end
                    state_next.digit_accumulator = '0;
                    state_next.digits_taken      = '0;
                end
            end
            if (base.byte_position != '1)
            begin
                state_next.byte_position = base.byte_position + 1'b1;
            end
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && produce;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            field_index_reg <= base.current_field;
            field_value_reg <= base.digit_accumulator;
            error_reg       <= state_next.mismatch_flag;
            last_reg        <= base.current_field == FIELD_W'(FIELD_COUNT - 1);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-FIELD_W-VALUE_W){1'b0}},
                            field_value_reg, field_index_reg};
    assign m_axis_tuser  = error_reg;
    assign m_axis_tlast  = last_reg;

    a_last_is_final_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> field_index_reg == FIELD_W'(FIELD_COUNT - 1))
        else $error("message end on a field other than the final one");

    a_clean_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> field_value_reg <= VALUE_W'(9999))
        else $error("field value out of decimal range without error");

    a_digit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.digits_taken <= DIGIT_CNT_W'(DIGITS_PER_FIELD))
        else $error("digit count beyond field width");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> $stable(state_reg))
        else $error("parse state moved while stalled");

endmodule

>>> dv/template_checked_field_extractor_top_test.sv
// Self-checking testbench for template_checked_field_extractor_top.
// Drives ASCII messages on s_axis, predicts each field result and checks m_axis.
// Depends on tcfe_pkg and the top level in hdl.
`timescale 1ns / 1ps

module template_checked_field_extractor_top_test;
    import tcfe_pkg::*;

    localparam int MSG_BYTES   = FRAME_LENGTH_DEF - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 16;

    typedef struct packed {
        logic [FIELD_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               err;
        logic               last;
    } field_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    string msg_template =
        {"mMin:0000,mMax:0000,hMin:0000,hMax:0000,tMin:0000,tMax:0000,",
         "iMin:0000,iMax:0000,h:0000,t:0000,nID:0000,"};

    // parser state mirrored by the predictor
    logic [POS_W-1:0]       rx_pos;
    logic [FIELD_W-1:0]     rx_field;
    logic [VALUE_W-1:0]     rx_acc;
    logic                   rx_err;
    logic [DIGIT_CNT_W-1:0] rx_digits;

    field_result_t pending_fields[$];
    logic [7:0]    msg_buf[MSG_BYTES];
    int            field_vals[FIELD_COUNT_DEF];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  bytes_parsed = 0;
    int  stall_left = 0;
    bit  src_idle_en = 1'b1;
    bit  sink_idle_en = 1'b1;

    template_checked_field_extractor_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] template_char(input int pos);
        logic [7:0] c;
        c = 8'h00;
        if (pos < msg_template.len())
        begin
            c = msg_template[pos];
        end
        return c;
    endfunction

    function automatic bit is_digit_char(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic void clear_parser();
        rx_pos    = '0;
        rx_field  = '0;
        rx_acc    = '0;
        rx_err    = 1'b0;
        rx_digits = '0;
    endfunction

    // Advance the mirrored parser by one accepted byte; queue a field result at a comma.
    function automatic void parse_byte(input logic [7:0] b, input logic sop);
        logic [7:0]    t;
        logic [3:0]    d;
        field_result_t r;
        if (sop)
        begin
            clear_parser();
        end
        if (int'(rx_pos) >= MSG_BYTES)
        begin
            return;
        end
        bytes_parsed++;
        t = template_char(int'(rx_pos));
        if (is_digit_char(t))
        begin
            d = 4'd0;
            if (is_digit_char(b))
            begin
                d = 4'(b - CHAR_ZERO);
            end
            else
            begin
                rx_err = 1'b1;
            end
            if (int'(rx_digits) < DIGITS_PER_FIELD_DEF)
            begin
                rx_acc    = VALUE_W'(rx_acc * 10 + d);
                rx_digits = rx_digits + 1'b1;
            end
        end
        else
        begin
            if (b != t)
            begin
                rx_err = 1'b1;
            end
            if (t == CHAR_COMMA)
            begin
                if (int'(rx_field) < FIELD_COUNT_DEF)
                begin
                    r.index = rx_field;
                    r.value = rx_acc;
                    r.err   = rx_err;
                    r.last  = (int'(rx_field) == FIELD_COUNT_DEF - 1);
                    pending_fields.push_back(r);
                end
                if (rx_field != 4'd15)
                begin
                    rx_field = rx_field + 1'b1;
                end
                rx_acc    = '0;
                rx_digits = '0;
            end
        end
        if (rx_pos != 7'd127)
        begin
            rx_pos = rx_pos + 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 100)
        begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                     want);
        end
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        field_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_fields.size() == 0)
            begin
                report_mismatch("unexpected field result, index", int'(m_axis_tdata[3:0]), -1);
            end
            else
            begin
                want = pending_fields.pop_front();
                if (m_axis_tdata[3:0] != want.index)
                    report_mismatch("field_index", int'(m_axis_tdata[3:0]), int'(want.index));
                if (m_axis_tdata[17:4] != want.value)
                    report_mismatch("field_value", int'(m_axis_tdata[17:4]), int'(want.value));
                if (m_axis_tdata[23:18] != '0)
                    report_mismatch("tdata padding", int'(m_axis_tdata[23:18]), 0);
                if (m_axis_tuser !== want.err)
                    report_mismatch("error_so_far", int'(m_axis_tuser), int'(want.err));
                if (m_axis_tlast !== want.last)
                    report_mismatch("message_last", int'(m_axis_tlast), int'(want.last));
            end
        end
    end

    always @(negedge clk)
    begin
        if (!sink_idle_en)
        begin
            m_axis_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left    <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_byte(input logic [7:0] b, input logic sop);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= sop;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_byte(b, sop);
        @(negedge clk);
    endtask

    function automatic void fill_message();
        int f;
        int k;
        int divisor;
        logic [7:0] t;
        f = 0;
        k = 0;
        for (int p = 0; p < MSG_BYTES; p++)
        begin
            t = template_char(p);
            if (is_digit_char(t))
            begin
                divisor = (k == 0) ? 1000 : (k == 1) ? 100 : (k == 2) ? 10 : 1;
                msg_buf[p] = CHAR_ZERO + 8'((field_vals[f] / divisor) % 10);
                k++;
            end
            else
            begin
                msg_buf[p] = t;
                if (t == CHAR_COMMA)
                begin
                    f++;
                    k = 0;
                end
            end
        end
    endfunction

    function automatic void random_fields();
        int sel;
        for (int f = 0; f < FIELD_COUNT_DEF; f++)
        begin
            sel = $urandom_range(0, 7);
            field_vals[f] = (sel == 0) ? 0 : (sel == 1) ? 9999 : $urandom_range(0, 9999);
        end
        fill_message();
    endfunction

    task automatic send_buf(input int len, input logic sop_first);
        for (int p = 0; p < len; p++)
        begin
            send_byte(msg_buf[p], sop_first && (p == 0));
        end
    endtask

    function automatic logic [7:0] random_bad_byte();
        int sel;
        logic [7:0] b;
        sel = $urandom_range(0, 5);
        case (sel)
            0: b = CHAR_ZERO - 8'd1;
            1: b = CHAR_NINE + 8'd1;
            2: b = 8'h00;
            3: b = 8'hff;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    task automatic test_reset_start();
        for (int f = 0; f < FIELD_COUNT_DEF; f++)
            field_vals[f] = 0;
        fill_message();
        send_buf(MSG_BYTES, 1'b0);
    endtask

    task automatic test_value_extremes();
        int mix[FIELD_COUNT_DEF] = '{0, 9999, 1, 9000, 1234, 5678, 4321, 8765, 10, 999, 9998};
        for (int f = 0; f < FIELD_COUNT_DEF; f++)
            field_vals[f] = 9999;
        fill_message();
        send_buf(MSG_BYTES, 1'b1);
        field_vals = mix;
        fill_message();
        send_buf(MSG_BYTES, 1'b1);
    endtask

    task automatic test_past_end();
        for (int i = 0; i < 30; i++)
        begin
            send_byte((i % 3 == 0) ? CHAR_COMMA : 8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic test_bad_digits();
        random_fields();
        msg_buf[5]  = CHAR_ZERO - 8'd1;
        msg_buf[16] = CHAR_NINE + 8'd1;
        msg_buf[27] = 8'h00;
        msg_buf[38] = 8'hff;
        msg_buf[50] = "a";
        send_buf(MSG_BYTES, 1'b1);
        random_fields();
        msg_buf[MSG_BYTES-2] = 8'h80;
        send_buf(MSG_BYTES, 1'b1);
    endtask

    task automatic test_bad_literals();
        random_fields();
        msg_buf[0]  = "M";
        send_buf(MSG_BYTES, 1'b1);
        random_fields();
        msg_buf[4]  = ";";
        msg_buf[9]  = ".";
        msg_buf[MSG_BYTES-1] = 8'h00;
        send_buf(MSG_BYTES, 1'b1);
    endtask

    task automatic test_resync();
        random_fields();
        send_buf(50, 1'b1);
        random_fields();
        send_buf(MSG_BYTES, 1'b1);
    endtask

    task automatic test_random_traffic();
        int target;
        int kind;
        int cuts;
        int len;
        target = bytes_parsed + 700;
        while (bytes_parsed < target)
        begin
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            random_fields();
            case (kind)
                6:
                begin
                    msg_buf[$urandom_range(0, MSG_BYTES-1)] = random_bad_byte();
                    send_buf(MSG_BYTES, 1'b1);
                end
                7:
                begin
                    cuts = $urandom_range(2, 4);
                    for (int i = 0; i < cuts; i++)
                        msg_buf[$urandom_range(0, MSG_BYTES-1)] = 8'($urandom_range(0, 255));
                    send_buf(MSG_BYTES, 1'b1);
                end
                8:
                begin
                    send_buf($urandom_range(1, MSG_BYTES-1), 1'b1);
                end
                9:
                begin
                    len = $urandom_range(1, 20);
                    for (int i = 0; i < len; i++)
                        send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
                end
                default:
                begin
                    send_buf(MSG_BYTES, ($urandom_range(0, 15) != 0));
                end
            endcase
        end
    endtask

    task automatic test_no_idle_tail();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            random_fields();
            send_buf(MSG_BYTES, 1'b1);
        end
    endtask

    initial
    begin
        clear_parser();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_start();
        test_value_extremes();
        test_past_end();
        test_bad_digits();
        test_bad_literals();
        test_resync();
        test_random_traffic();
        test_no_idle_tail();
        s_axis_tvalid <= 1'b0;
        while (pending_fields.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
